[rtl/pstk_pkg.sv]
// ----------------------------------------------------------------------------
// pstk_pkg
// Shared types and constants for the priority stack: command and status
// codes, transfer payload structs and cell control.
// ----------------------------------------------------------------------------
package pstk_pkg;

  localparam int unsigned VAL_FIELD_W  = 32;
  localparam int unsigned PRIO_FIELD_W = 8;
  localparam int unsigned CNT_FIELD_W  = 5;

  // widest storage the parameters may ask for
  localparam int unsigned VAL_MAX_W  = 64;
  localparam int unsigned PRIO_MAX_W = 32;
  localparam int unsigned CNT_MAX_W  = 32;

  localparam int unsigned DEPTH_DEF          = 16;
  localparam int unsigned VALUE_WIDTH_DEF    = 32;
  localparam int unsigned PRIORITY_WIDTH_DEF = 8;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [VAL_FIELD_W-1:0]  push_value;
    logic [PRIO_FIELD_W-1:0] push_priority;
  } in_item_t;

  typedef struct packed {
    logic [VAL_FIELD_W-1:0]  top_value;
    logic [PRIO_FIELD_W-1:0] top_priority;
    logic                    is_empty;
    logic [CNT_FIELD_W-1:0]  entry_count;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

[rtl/pstk_cell.sv]
// ----------------------------------------------------------------------------
// pstk_cell
// One slot of the sorted stack. On push it keeps its entry, takes the new
// entry or takes its upper neighbor's; on pop it takes its lower neighbor's.
// ----------------------------------------------------------------------------
module pstk_cell
  import pstk_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic [VALUE_WIDTH-1:0]    new_value_i,
  input  logic [PRIORITY_WIDTH-1:0] new_priority_i,
  input  logic [VALUE_WIDTH-1:0]    up_value_i,
  input  logic [PRIORITY_WIDTH-1:0] up_priority_i,
  input  logic                      up_valid_i,
  input  logic                      up_keep_i,
  input  logic [VALUE_WIDTH-1:0]    dn_value_i,
  input  logic [PRIORITY_WIDTH-1:0] dn_priority_i,
  input  logic                      dn_valid_i,
  output logic [VALUE_WIDTH-1:0]    value_o,
  output logic [PRIORITY_WIDTH-1:0] priority_o,
  output logic                      valid_o,
  output logic                      keep_o
);

  logic [VALUE_WIDTH-1:0]    value_q, value_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic                      valid_q, valid_d;
  logic                      keep;

  // entry stays put on push when it outranks the new one
  assign keep = valid_q && (prio_q > new_priority_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    valid_d = valid_q;
    if (ctrl_i.push) begin
      valid_d = valid_q | up_valid_i;
      if (!keep) begin
        if (up_keep_i) begin
          value_d = new_value_i;
          prio_d  = new_priority_i;
        end else begin
          value_d = up_value_i;
          prio_d  = up_priority_i;
        end
      end
    end else if (ctrl_i.pop) begin
      value_d = dn_value_i;
      prio_d  = dn_priority_i;
      valid_d = dn_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o    = value_q;
  assign priority_o = prio_q;
  assign valid_o    = valid_q;
  assign keep_o     = keep;

endmodule

[rtl/priority_stack.sv]
// ----------------------------------------------------------------------------
// priority_stack
// Bounded priority stack of value/priority pairs, highest priority on top,
// newest first among equal priorities. Built as a row of cells.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------
//   in      | input     | in_valid_i/in_stall_o   | in_item_t
//   out     | output    | out_valid_o/out_stall_i | out_item_t
//
// One command per cycle while in_stall_o is low; every cell compares against the broadcast push
// priority and shifts with its neighbors in the same cycle.
// The result appears in the cycle after the input transfer, in an output
// register; a new command is taken while that result is being drained.
// Reset clears the cell valid flags and the count; no clearing pass.
// in_stall_o rises only while a result waits and out_stall_i is high.
// ----------------------------------------------------------------------------
module priority_stack
  import pstk_pkg::*;
#(
  parameter int unsigned DEPTH          = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                      accept;
  logic                      full, empty;
  cell_ctrl_t                ctrl;
  status_e                   status_q, status_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q, out_valid_d;

  logic [VAL_MAX_W-1:0]      push_val_w;
  logic [PRIO_MAX_W-1:0]     push_prio_w;
  logic [VALUE_WIDTH-1:0]    push_val;
  logic [PRIORITY_WIDTH-1:0] push_prio;
  logic [VAL_MAX_W-1:0]      top_val_w;
  logic [PRIO_MAX_W-1:0]     top_prio_w;
  logic [CNT_MAX_W-1:0]      cnt_w;

  logic [VALUE_WIDTH-1:0]    cell_val  [DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0]          cell_keep;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  assign push_val_w  = VAL_MAX_W'(in_data_i.push_value);
  assign push_prio_w = PRIO_MAX_W'(in_data_i.push_priority);
  assign push_val    = push_val_w[VALUE_WIDTH-1:0];
  assign push_prio   = push_prio_w[PRIORITY_WIDTH-1:0];

  always_comb begin
    ctrl     = '0;
    status_d = status_q;
    count_d  = count_q;
    if (accept) begin
      status_d = ST_OK;
      unique case (in_data_i.command)
        CMD_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            count_d   = count_q + CNT_W'(1);
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0]    up_val, dn_val;
    logic [PRIORITY_WIDTH-1:0] up_prio, dn_prio;
    logic                      up_valid, up_keep, dn_valid;

    if (k == 0) begin : g_top
      assign up_val   = push_val;
      assign up_prio  = push_prio;
      assign up_valid = 1'b1;
      assign up_keep  = 1'b1;
    end else begin : g_mid
      assign up_val   = cell_val[k-1];
      assign up_prio  = cell_prio[k-1];
      assign up_valid = cell_valid[k-1];
      assign up_keep  = cell_keep[k-1];
    end

    if (k == DEPTH - 1) begin : g_bot
      assign dn_val   = cell_val[k];
      assign dn_prio  = cell_prio[k];
      assign dn_valid = 1'b0;
    end else begin : g_inner
      assign dn_val   = cell_val[k+1];
      assign dn_prio  = cell_prio[k+1];
      assign dn_valid = cell_valid[k+1];
    end

    pstk_cell #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_value_i    (push_val),
      .new_priority_i (push_prio),
      .up_value_i     (up_val),
      .up_priority_i  (up_prio),
      .up_valid_i     (up_valid),
      .up_keep_i      (up_keep),
      .dn_value_i     (dn_val),
      .dn_priority_i  (dn_prio),
      .dn_valid_i     (dn_valid),
      .value_o        (cell_val[k]),
      .priority_o     (cell_prio[k]),
      .valid_o        (cell_valid[k]),
      .keep_o         (cell_keep[k])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result reads the settled state; it holds while the output stalls
  assign top_val_w  = VAL_MAX_W'(cell_val[0]);
  assign top_prio_w = PRIO_MAX_W'(cell_prio[0]);
  assign cnt_w      = CNT_MAX_W'(count_q);

  always_comb begin
    out_data_o.top_value    = empty ? '0 : top_val_w[VAL_FIELD_W-1:0];
    out_data_o.top_priority = empty ? '0 : top_prio_w[PRIO_FIELD_W-1:0];
    out_data_o.is_empty     = empty;
    out_data_o.entry_count  = cnt_w[CNT_FIELD_W-1:0];
    out_data_o.status       = status_q;
  end

  assign out_valid_o = out_valid_q;

  a_valid_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("cell valid flags disagree with held count");

  a_top_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == !empty)
    else $error("top cell valid flag disagrees with empty");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("count did not grow after push");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("count did not shrink after pop");

endmodule

[sim/priority_stack_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_stack_tb
// Self-checking bench for the priority stack. A directed set of commands
// covers the empty and full cases, the extremes and equal-priority ties.
// Bursts of random push, pop and query commands follow, each burst leaning
// toward filling, draining or churning the store. A local model predicts
// each result, and every output transfer is checked field by field. The
// input and output sides idle and stall at rates that change between phases.
// ----------------------------------------------------------------------------
module priority_stack_tb
  import pstk_pkg::*;
;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  in_item_t  cmd_queue[$];
  out_item_t top_expected[$];

  logic [VAL_FIELD_W-1:0]  model_val [STACK_DEPTH];
  logic [PRIO_FIELD_W-1:0] model_prio[STACK_DEPTH];
  int model_cnt    = 0;
  int n_total      = 1;
  int n_accepted   = 0;
  int n_results    = 0;
  int n_errors     = 0;
  int n_pushes     = 0;
  int n_pops       = 0;
  int n_full_drops = 0;
  int n_empty_pops = 0;
  int cycle_cnt    = 0;
  int idle_pct;
  int stall_pct;

  priority_stack u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one command to the local stack and queue the top it leaves.
  task automatic apply_command(input in_item_t cmd);
    out_item_t res;
    int pos;
    res = '0;
    res.status = ST_OK;
    case (cmd.command)
      CMD_PUSH: begin
        if (model_cnt >= STACK_DEPTH) begin
          res.status = ST_FULL;
          n_full_drops++;
        end else begin
          pos = 0;
          while (pos < model_cnt && model_prio[pos] > cmd.push_priority) pos++;
          for (int k = model_cnt; k > pos; k--) begin
            model_val[k]  = model_val[k-1];
            model_prio[k] = model_prio[k-1];
          end
          model_val[pos]  = cmd.push_value;
          model_prio[pos] = cmd.push_priority;
          model_cnt++;
          n_pushes++;
        end
      end
      CMD_POP: begin
        if (model_cnt == 0) begin
          res.status = ST_EMPTY;
          n_empty_pops++;
        end else begin
          for (int k = 0; k + 1 < model_cnt; k++) begin
            model_val[k]  = model_val[k+1];
            model_prio[k] = model_prio[k+1];
          end
          model_cnt--;
          n_pops++;
        end
      end
      default: ;
    endcase
    if (model_cnt > 0) begin
      res.top_value    = model_val[0];
      res.top_priority = model_prio[0];
      res.is_empty     = 1'b0;
    end else begin
      res.is_empty = 1'b1;
    end
    res.entry_count = CNT_FIELD_W'(model_cnt);
    top_expected.push_back(res);
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("ERROR result %0d: %s expected 0x%0h got 0x%0h", n_results, what, want, got);
    n_errors++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (top_expected.size() == 0) begin
      report("unexpected transfer", '0, 64'(got));
    end else begin
      want = top_expected.pop_front();
      if (got.top_value !== want.top_value)
        report("top_value", 64'(want.top_value), 64'(got.top_value));
      if (got.top_priority !== want.top_priority)
        report("top_priority", 64'(want.top_priority), 64'(got.top_priority));
      if (got.is_empty !== want.is_empty)
        report("is_empty", 64'(want.is_empty), 64'(got.is_empty));
      if (got.entry_count !== want.entry_count)
        report("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      if (got.status !== want.status)
        report("status", 64'(want.status), 64'(got.status));
    end
    n_results++;
  endtask

  task automatic add_cmd(input logic [1:0] c, input logic [31:0] v, input logic [7:0] p);
    in_item_t it;
    it.command       = c;
    it.push_value    = v;
    it.push_priority = p;
    cmd_queue.push_back(it);
  endtask

  always @* begin
    case ((n_accepted * 4) / n_total)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 52; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 52; end
      default: begin idle_pct = 9;  stall_pct = 9;  end
    endcase
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_command(in_data_i);
        n_accepted++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data_i  <= cmd_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, top_expected.size());
      $display("priority_stack: mismatch");
      $finish;
    end
  end

  initial begin
    int mode;
    int r;
    logic [1:0]  c;
    logic [31:0] v;
    logic [7:0]  p;

    // empty-store cases
    add_cmd(CMD_QUERY, 32'hFFFF_FFFF, 8'hFF);
    add_cmd(CMD_POP,   32'h0,         8'h0);
    add_cmd(CMD_SPARE, 32'hDEAD_BEEF, 8'h5A);
    // fill with extremes and ties
    add_cmd(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF);
    add_cmd(CMD_PUSH, 32'h0000_0000, 8'h00);
    add_cmd(CMD_PUSH, 32'h0000_0001, 8'h80);
    add_cmd(CMD_PUSH, 32'h0000_0002, 8'h80);
    add_cmd(CMD_PUSH, 32'h8000_0000, 8'hFF);
    add_cmd(CMD_PUSH, 32'h5555_5555, 8'h00);
    for (int i = 0; i < 10; i++) add_cmd(CMD_PUSH, 32'hA5A5_0000 + i, 8'(i % 3) + 8'h7F);
    add_cmd(CMD_PUSH, 32'h1234_5678, 8'hFF);
    add_cmd(CMD_SPARE, 32'h0, 8'h0);
    add_cmd(CMD_POP,   32'h0, 8'h0);
    add_cmd(CMD_POP,   32'h0, 8'h0);
    add_cmd(CMD_QUERY, 32'h0, 8'h0);

    // random bursts: fill, drain, churn near full, balanced
    for (int b = 0; b < 30; b++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 40; i++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       c = (r < 78) ? CMD_PUSH : (r < 93) ? CMD_POP : CMD_QUERY;
          1:       c = (r < 20) ? CMD_PUSH : (r < 92) ? CMD_POP : CMD_QUERY;
          2:       c = (r < 60) ? CMD_PUSH : (r < 95) ? CMD_POP : CMD_QUERY;
          default: c = (r < 47) ? CMD_PUSH : (r < 92) ? CMD_POP : CMD_QUERY;
        endcase
        if ($urandom_range(0, 49) == 0) c = CMD_SPARE;
        r = $urandom_range(0, 9);
        v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        r = $urandom_range(0, 9);
        if (r < 4)       p = 8'($urandom_range(0, 3));
        else if (r == 4) p = 8'hFF;
        else if (r == 5) p = 8'h00;
        else             p = 8'($urandom_range(0, 255));
        add_cmd(c, v, p);
      end
    end
    n_total = cmd_queue.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid_i || top_expected.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d commands, %0d results: %0d pushes, %0d pops, %0d pushes on full,",
             n_accepted, n_results, n_pushes, n_pops, n_full_drops);
    $display("%0d pops on empty, %0d field errors", n_empty_pops, n_errors);
    if (n_errors == 0) begin
      $display("priority_stack: match");
    end else begin
      $display("priority_stack: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pstk_pkg.sv
rtl/pstk_cell.sv
rtl/priority_stack.sv
sim/priority_stack_tb.sv
